// File: rtl/core/fwm_pkg.sv
// ----------------------------------------------------------------------------
// fwm_pkg
// Shared constants and types for the forward window median filter.
// ----------------------------------------------------------------------------
package fwm_pkg;

    localparam int MAX_WINDOW = 8;
    localparam int MAX_WIDTH  = 1024;
    localparam int ROW_BITS   = $clog2(MAX_WINDOW);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
    localparam int DEPTH      = MAX_WINDOW * MAX_WIDTH;

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        T_IDLE,
        T_START,
        T_WAIT,
        T_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        SL_IDLE,
        SL_READ,
        SL_TAIL,
        SL_DONE
    } sel_state_t;

    // median request toward the selection unit
    typedef struct packed {
        logic        start;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [3:0]  win;
        logic [10:0] hgt;
        logic [10:0] wid;
    } sel_req_t;

    // median response from the selection unit
    typedef struct packed {
        logic       done;
        logic [7:0] median;
    } sel_rsp_t;

endpackage

// File: rtl/core/fwm_line_ram.sv
// ----------------------------------------------------------------------------
// fwm_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fwm_line_ram
    import fwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [7:0]           wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [7:0]           rd_data
);

    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/core/fwm_select.sv
// ----------------------------------------------------------------------------
// fwm_select
// Median selection by radix search: eight passes over the clipped window,
// one bit of the result decided per pass, one line store read per cycle.
// ----------------------------------------------------------------------------
module fwm_select
    import fwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sel_req_t             req,
    output sel_rsp_t             rsp,
    output logic [ADDR_BITS-1:0] rd_addr,
    input  logic [7:0]           rd_data
);

    sel_state_t state_reg, state_next;

    logic [9:0] row_reg, col_reg;
    logic [3:0] nrows_reg, ncols_reg;
    logic [2:0] roff_reg, coff_reg;
    logic [2:0] bit_reg;
    logic [6:0] rank_reg, cnt_reg;
    logic [7:0] prefix_reg;
    logic       rd_valid_reg;

    logic [10:0] rend, cend, h1, w1;
    logic [3:0]  nrows, ncols;
    logic [7:0]  nprod;
    logic [7:0]  hmask;
    logic        hit;
    logic [6:0]  cnt_fin;
    logic        scan_last;
    logic        issue;
    logic [9:0]  rd_row, rd_col;

    // window extent clipped at the bottom and right edges
    always_comb
    begin
        rend  = {1'b0, req.row} + {7'b0, req.win} - 11'd1;
        cend  = {1'b0, req.col} + {7'b0, req.win} - 11'd1;
        h1    = req.hgt - 11'd1;
        w1    = req.wid - 11'd1;
        if (h1 < rend)
        begin
            rend = h1;
        end
        if (w1 < cend)
        begin
            cend = w1;
        end
        nrows = 4'(rend - {1'b0, req.row} + 11'd1);
        ncols = 4'(cend - {1'b0, req.col} + 11'd1);
        nprod = nrows * ncols;
    end

    // compare of the returning value against the bits decided so far
    always_comb
    begin
        hmask   = 8'hFE << bit_reg;
        hit     = rd_valid_reg && (((rd_data ^ prefix_reg) & hmask) == 8'd0)
                  && !rd_data[bit_reg];
        cnt_fin = cnt_reg + {6'd0, hit};
    end

    assign scan_last = (roff_reg == 3'(nrows_reg - 4'd1))
                    && (coff_reg == 3'(ncols_reg - 4'd1));
    assign rd_row    = row_reg + {7'd0, roff_reg};
    assign rd_col    = col_reg + {7'd0, coff_reg};
    assign rd_addr   = {rd_row[ROW_BITS-1:0], rd_col};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SL_IDLE:
            begin
                if (req.start)
                begin
                    state_next = SL_READ;
                end
            end
            SL_READ:
            begin
                if (scan_last)
                begin
                    state_next = SL_TAIL;
                end
            end
            SL_TAIL:
            begin
                if (bit_reg == 3'd0)
                begin
                    state_next = SL_DONE;
                end
                else
                begin
                    state_next = SL_READ;
                end
            end
            SL_DONE:
            begin
                state_next = SL_IDLE;
            end
            default:
            begin
                state_next = SL_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        issue      = 1'b0;
        rsp.done   = 1'b0;
        rsp.median = prefix_reg;
        case (state_reg)
            SL_READ:
            begin
                issue = 1'b1;
            end
            SL_DONE:
            begin
                rsp.done = 1'b1;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SL_IDLE;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            SL_IDLE:
            begin
                row_reg    <= req.row;
                col_reg    <= req.col;
                nrows_reg  <= nrows;
                ncols_reg  <= ncols;
                roff_reg   <= 3'd0;
                coff_reg   <= 3'd0;
                bit_reg    <= 3'd7;
                rank_reg   <= 7'(nprod >> 1);
                cnt_reg    <= 7'd0;
                prefix_reg <= 8'd0;
            end
            SL_READ:
            begin
                cnt_reg <= cnt_fin;
                if (coff_reg == 3'(ncols_reg - 4'd1))
                begin
                    coff_reg <= 3'd0;
                    roff_reg <= roff_reg + 3'd1;
                end
                else
                begin
                    coff_reg <= coff_reg + 3'd1;
                end
            end
            SL_TAIL:
            begin
                // decide this bit and restart the scan for the next one
                if (rank_reg >= cnt_fin)
                begin
                    prefix_reg[bit_reg] <= 1'b1;
                    rank_reg            <= rank_reg - cnt_fin;
                end
                cnt_reg  <= 7'd0;
                roff_reg <= 3'd0;
                coff_reg <= 3'd0;
                bit_reg  <= bit_reg - 3'd1;
            end
            default:
            begin
                cnt_reg <= 7'd0;
            end
        endcase
    end

endmodule

// File: rtl/core/forward_window_median_filter_core.sv
// ----------------------------------------------------------------------------
// forward_window_median_filter_core
// Streaming 2-D median filter with a top-left anchored window.
// ----------------------------------------------------------------------------
// Pixels are written into an 8-row line store as they arrive. A pixel that
// completes one or more windows produces those results in raster order, each
// carrying its row and column, run_last marking the final one for that pixel.
// Each median is found by an eight-pass radix search that reads the window
// from the line store once per pass, one value per cycle; a finished result
// beat may then wait on out_ready. No new pixel is taken until the last
// result of a run is loaded, while a pixel that completes no window leaves
// the block ready for another pixel. The single read port of the line store
// sets the pace of the search. Any configuration write restarts the frame at
// row 0, column 0.
// ----------------------------------------------------------------------------
module forward_window_median_filter_core
    import fwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  out_row,
    output logic [9:0]  out_col,
    output logic [7:0]  filtered,
    output logic        run_last
);

    top_state_t state_reg, state_next;

    logic [3:0]  ws_reg;
    logic [10:0] iw_reg, ih_reg;
    logic [9:0]  cur_row_reg, cur_col_reg;
    logic [9:0]  i_reg, j_reg, i1_reg, j0_reg, j1_reg;
    logic [7:0]  med_reg;
    logic        out_valid_reg;
    logic [9:0]  out_row_reg, out_col_reg;
    logic [7:0]  out_med_reg;
    logic        out_last_reg;

    logic [3:0]  win;
    logic [10:0] wid, hgt, w11;
    logic [9:0]  r_eff, c_eff;
    logic        r_last, c_last, rows_ok, cols_ok;
    logic [10:0] i0, i1, j0, j1;
    logic [10:0] c_inc, r_inc;
    logic        in_beat, cfg_beat, load_out, run_end;

    sel_req_t             req;
    sel_rsp_t             rsp;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [7:0]           rd_data;

    // clamped configuration
    always_comb
    begin
        win = ws_reg;
        if (ws_reg == 4'd0)
        begin
            win = 4'd1;
        end
        else if (ws_reg > 4'(MAX_WINDOW))
        begin
            win = 4'(MAX_WINDOW);
        end
        wid = iw_reg;
        if (iw_reg == 11'd0)
        begin
            wid = 11'd1;
        end
        else if (iw_reg > 11'(MAX_WIDTH))
        begin
            wid = 11'(MAX_WIDTH);
        end
        hgt = ih_reg;
        if (ih_reg == 11'd0)
        begin
            hgt = 11'd1;
        end
        else if (ih_reg > 11'd1024)
        begin
            hgt = 11'd1024;
        end
        w11 = {7'd0, win};
    end

    // position of the arriving pixel and the windows it completes
    always_comb
    begin
        r_eff = cur_row_reg;
        c_eff = cur_col_reg;
        if ({1'b0, cur_row_reg} >= hgt || {1'b0, cur_col_reg} >= wid)
        begin
            r_eff = 10'd0;
            c_eff = 10'd0;
        end
        r_last  = ({1'b0, r_eff} == hgt - 11'd1);
        c_last  = ({1'b0, c_eff} == wid - 11'd1);
        rows_ok = r_last || ({1'b0, r_eff} + 11'd1 >= w11);
        cols_ok = c_last || ({1'b0, c_eff} + 11'd1 >= w11);
        if (r_last)
        begin
            i0 = (hgt > w11) ? hgt - w11 : 11'd0;
            i1 = hgt - 11'd1;
        end
        else
        begin
            i0 = {1'b0, r_eff} + 11'd1 - w11;
            i1 = i0;
        end
        if (c_last)
        begin
            j0 = (wid > w11) ? wid - w11 : 11'd0;
            j1 = wid - 11'd1;
        end
        else
        begin
            j0 = {1'b0, c_eff} + 11'd1 - w11;
            j1 = j0;
        end
        c_inc = {1'b0, c_eff} + 11'd1;
        r_inc = {1'b0, r_eff} + 11'd1;
    end

    assign in_beat  = in_valid && in_ready;
    assign cfg_beat = cfg_valid && cfg_ready;
    assign run_end  = (i_reg == i1_reg) && (j_reg == j1_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_beat && rows_ok && cols_ok)
                begin
                    state_next = T_START;
                end
            end
            T_START:
            begin
                state_next = T_WAIT;
            end
            T_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = T_EMIT;
                end
            end
            T_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = run_end ? T_IDLE : T_START;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        req.start = 1'b0;
        req.row   = i_reg;
        req.col   = j_reg;
        req.win   = win;
        req.hgt   = hgt;
        req.wid   = wid;
        load_out  = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                // a waiting pixel beat goes ahead of a register write
                in_ready  = 1'b1;
                cfg_ready = !in_valid;
            end
            T_START:
            begin
                req.start = 1'b1;
            end
            T_EMIT:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control state, configuration and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            ws_reg        <= 4'd3;
            iw_reg        <= 11'd1024;
            ih_reg        <= 11'd1024;
            cur_row_reg   <= 10'd0;
            cur_col_reg   <= 10'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_beat)
            begin
                case (cfg_index)
                    REG_WINDOW_SIZE:  ws_reg <= cfg_data[3:0];
                    REG_IMAGE_WIDTH:  iw_reg <= cfg_data;
                    REG_IMAGE_HEIGHT: ih_reg <= cfg_data;
                    default:          ws_reg <= ws_reg;
                endcase
                cur_row_reg <= 10'd0;
                cur_col_reg <= 10'd0;
            end
            else if (in_beat)
            begin
                if (c_inc >= wid)
                begin
                    cur_col_reg <= 10'd0;
                    cur_row_reg <= (r_inc >= hgt) ? 10'd0 : r_inc[9:0];
                end
                else
                begin
                    cur_col_reg <= c_inc[9:0];
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // run of results for the current pixel
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            i_reg  <= i0[9:0];
            i1_reg <= i1[9:0];
            j_reg  <= j0[9:0];
            j0_reg <= j0[9:0];
            j1_reg <= j1[9:0];
        end
        else if (load_out && !run_end)
        begin
            if (j_reg == j1_reg)
            begin
                j_reg <= j0_reg;
                i_reg <= i_reg + 10'd1;
            end
            else
            begin
                j_reg <= j_reg + 10'd1;
            end
        end
        if (rsp.done)
        begin
            med_reg <= rsp.median;
        end
        if (load_out)
        begin
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_med_reg  <= med_reg;
            out_last_reg <= run_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign filtered  = out_med_reg;
    assign run_last  = out_last_reg;

    fwm_line_ram u_ram (
        .clk     (clk),
        .wr_en   (in_beat),
        .wr_addr ({r_eff[ROW_BITS-1:0], c_eff}),
        .wr_data (pixel),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fwm_select u_sel (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// File: rtl/core/fwm_checker.sv
// ----------------------------------------------------------------------------
// fwm_checker
// Port-level checks for the median filter core, bound to the top level.
// ----------------------------------------------------------------------------
module fwm_checker
    import fwm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  out_row,
    input logic [9:0]  out_col,
    input logic [7:0]  filtered,
    input logic        run_last
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row)
        && $stable(out_col) && $stable(filtered) && $stable(run_last))
    else $error("stalled result beat changed");

    // while a run is unfinished no new pixel is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !in_ready)
    else $error("pixel accepted inside a result run");

    // the block only goes busy after taking a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
    else $error("input ready dropped without a pixel beat");

    // configuration is only taken while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> in_ready)
    else $error("configuration taken while busy");

endmodule

bind forward_window_median_filter_core fwm_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .filtered  (filtered),
    .run_last  (run_last)
);
